### rtl/shgrq_pkg.sv
// shared constants, codes and control types for the spatial hash grid radius query
// no dependencies
package shgrq_pkg;

    localparam int GRID_SIDE    = 8;
    localparam int BUCKET_DEPTH = 4;
    localparam int MAX_MATCHES  = 64;

    localparam int CELL_W   = $clog2(GRID_SIDE);
    localparam int CELLS    = GRID_SIDE * GRID_SIDE;
    localparam int CIDX_W   = $clog2(CELLS);
    localparam int SLOTS    = CELLS * BUCKET_DEPTH;
    localparam int ADDR_W   = $clog2(SLOTS);
    localparam int CNT_W    = $clog2(BUCKET_DEPTH + 1);
    localparam int MCNT_W   = $clog2(MAX_MATCHES + 1);
    localparam int WIN_W    = CELL_W + 1;

    localparam int ID_W     = 16;
    localparam int POS_W    = 24;
    localparam int RAD_W    = 20;
    localparam int BS_W     = 16;
    localparam int ENTRY_W  = ID_W + 3 * POS_W;
    localparam int SQ_W     = 2 * POS_W;
    localparam int D2_W     = SQ_W + 2;
    localparam int R2_W     = 2 * RAD_W;
    localparam int DIV_CNT_W = $clog2(POS_W + 1);

    localparam logic [BS_W-1:0] BS_RESET = 16'd1024;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    typedef enum logic [1:0] {
        KIND_MATCH    = 2'd0,
        KIND_NONE     = 2'd1,
        KIND_INSERTED = 2'd2,
        KIND_DROPPED  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        DIV_X,
        DIV_Y,
        DIV_R
    } t_div_sel;

    typedef enum logic [1:0] {
        SQ_NONE,
        SQ_X,
        SQ_Y,
        SQ_Z
    } t_sq_sel;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DX,
        ST_DXW,
        ST_DY,
        ST_DYW,
        ST_DR,
        ST_DRW,
        ST_WIN,
        ST_INS_RD,
        ST_INS_WR,
        ST_CNT_RD,
        ST_CNT_CHK,
        ST_ENT_RD,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SQ_Z,
        ST_CMP,
        ST_END
    } t_state;

    typedef struct packed {
        logic     load_in;
        logic     div_start;
        t_div_sel div_sel;
        logic     win_init;
        logic     ins_commit;
        logic     ent_first;
        logic     ent_next;
        logic     cell_next;
        t_sq_sel  sq;
        logic     match_take;
        logic     emit_end;
    } t_ctrl_cmd;

    typedef struct packed {
        logic div_done;
        logic is_query;
        logic cnt_zero;
        logic ent_last;
        logic cell_last;
        logic out_free;
        logic emit_need;
    } t_dp_sts;

endpackage

### rtl/shgrq_in_if.sv
// input channel: command, object id, position and radius with valid/ready
// depends on shgrq_pkg
interface shgrq_in_if;
    logic                              valid;
    logic                              ready;
    logic                              command;
    logic [shgrq_pkg::ID_W-1:0]        object_id;
    logic signed [shgrq_pkg::POS_W-1:0] pos_x;
    logic signed [shgrq_pkg::POS_W-1:0] pos_y;
    logic signed [shgrq_pkg::POS_W-1:0] pos_z;
    logic [shgrq_pkg::RAD_W-1:0]       radius;

    modport source (output valid, command, object_id, pos_x, pos_y, pos_z, radius,
                    input ready);
    modport sink   (input valid, command, object_id, pos_x, pos_y, pos_z, radius,
                    output ready);
endinterface

### rtl/shgrq_out_if.sv
// result channel: kind, found id, last and overflow with valid/ready
// depends on shgrq_pkg
interface shgrq_out_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 kind;
    logic [shgrq_pkg::ID_W-1:0] found_id;
    logic                       last;
    logic                       overflow;

    modport source (output valid, kind, found_id, last, overflow, input ready);
    modport sink   (input valid, kind, found_id, last, overflow, output ready);
endinterface

### rtl/shgrq_ram.sv
// generic simple dual-port ram with registered read
// no dependencies
module shgrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/shgrq_div.sv
// restoring unsigned divider, one quotient bit per cycle
// depends on shgrq_pkg
module shgrq_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [shgrq_pkg::POS_W-1:0]  i_dividend,
    input  logic [shgrq_pkg::BS_W-1:0]   i_divisor,
    output logic                         o_done,
    output logic [shgrq_pkg::POS_W-1:0]  o_quo,
    output logic [shgrq_pkg::BS_W-1:0]   o_rem
);
    logic [shgrq_pkg::POS_W-1:0]     r_quo, n_quo;
    logic [shgrq_pkg::BS_W-1:0]      r_rem, n_rem;
    logic [shgrq_pkg::DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                            r_busy, n_busy;
    logic                            r_done, n_done;
    logic [shgrq_pkg::BS_W:0]        trial;
    logic                            fits;

    always_comb begin
        trial = {r_rem, r_quo[shgrq_pkg::POS_W-1]};
        fits  = trial >= {1'b0, i_divisor};
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_quo  = i_dividend;
            n_rem  = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_quo = {r_quo[shgrq_pkg::POS_W-2:0], fits};
            n_rem = fits ? shgrq_pkg::BS_W'(trial - {1'b0, i_divisor})
                         : trial[shgrq_pkg::BS_W-1:0];
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == shgrq_pkg::DIV_CNT_W'(shgrq_pkg::POS_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
endmodule

### rtl/shgrq_dp.sv
// datapath: input latch, cell mapping, bucket stores, distance test and result register
// depends on shgrq_pkg, shgrq_in_if, shgrq_out_if, shgrq_ram, shgrq_div
module shgrq_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    shgrq_in_if.sink                   i_in,
    shgrq_out_if.source                o_out,
    input  logic                       i_cfg_we,
    input  logic [shgrq_pkg::BS_W-1:0] i_cfg_wdata,
    input  shgrq_pkg::t_ctrl_cmd       i_cmd,
    output shgrq_pkg::t_dp_sts         o_sts
);
    localparam int CW = shgrq_pkg::CELL_W;
    localparam int PW = shgrq_pkg::POS_W;

    // configuration and latched input
    logic [shgrq_pkg::BS_W-1:0]  r_bs;
    logic                        r_cmd_q;
    logic [shgrq_pkg::ID_W-1:0]  r_id;
    logic [PW-1:0]               r_px, r_py, r_pz;
    logic [shgrq_pkg::RAD_W-1:0] r_rad;
    logic [shgrq_pkg::BS_W-1:0]  bs_eff;

    // divider
    shgrq_pkg::t_div_sel         r_dsel;
    logic [PW-1:0]               div_dividend;
    logic                        div_done;
    logic [PW-1:0]               div_quo;
    logic [shgrq_pkg::BS_W-1:0]  div_rem;
    logic                        div_neg;
    logic [CW-1:0]               cell_mod;

    // window
    logic [CW-1:0]               r_u, r_v, r_s, r_su, r_sv;
    logic                        r_full;
    logic [shgrq_pkg::WIN_W-1:0] r_win_n, r_iu, r_iv;
    logic [CW-1:0]               win_u, win_v, cell_u, cell_v;
    logic [shgrq_pkg::CIDX_W-1:0] cell_idx, ins_idx;

    // stores
    logic [shgrq_pkg::CNT_W-1:0] cnt_rdata, cnt_eff, r_cnt, r_c;
    logic                        r_cvalid [shgrq_pkg::CELLS];
    logic                        cnt_we, ent_we;
    logic [shgrq_pkg::ADDR_W-1:0] ent_waddr, ent_raddr;
    logic [shgrq_pkg::ENTRY_W-1:0] ent_wdata, ent_rdata;
    logic                        room;

    // distance
    logic [PW-1:0]               e_x, e_y, e_z, sq_a, sq_b;
    logic [shgrq_pkg::ID_W-1:0]  e_id;
    logic [PW:0]                 diff;
    logic [PW-1:0]               mag;
    logic [shgrq_pkg::SQ_W-1:0]  r_sq;
    logic [shgrq_pkg::D2_W-1:0]  r_acc, d2;
    logic [shgrq_pkg::R2_W-1:0]  r_r2;
    logic                        match;

    // matches and output
    logic [shgrq_pkg::MCNT_W-1:0] r_nmatch;
    logic [shgrq_pkg::ID_W-1:0]   r_pend_id;
    logic                         r_ovf;
    logic                         n_full;
    logic                         r_ovalid;
    logic [1:0]                   r_kind;
    logic [shgrq_pkg::ID_W-1:0]   r_oid;
    logic                         r_olast, r_oovf;
    logic                         emit;
    logic [1:0]                   emit_kind;
    logic [shgrq_pkg::ID_W-1:0]   emit_id;
    logic                         emit_last, emit_ovf;
    logic                         out_free;

    assign bs_eff = (r_bs == '0) ? shgrq_pkg::BS_W'(1) : r_bs;

    always_comb begin
        case (i_cmd.div_sel)
            shgrq_pkg::DIV_X: div_dividend = r_px[PW-1] ? PW'(-r_px) : r_px;
            shgrq_pkg::DIV_Y: div_dividend = r_py[PW-1] ? PW'(-r_py) : r_py;
            default:          div_dividend = PW'(r_rad);
        endcase
    end

    shgrq_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (bs_eff),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    // floor division then positive modulo on the low quotient bits
    always_comb begin
        div_neg = (r_dsel == shgrq_pkg::DIV_X) ? r_px[PW-1] : r_py[PW-1];
        if (!div_neg) begin
            cell_mod = div_quo[CW-1:0];
        end else if (div_rem != '0) begin
            cell_mod = ~div_quo[CW-1:0];
        end else begin
            cell_mod = CW'(-div_quo[CW-1:0]);
        end
    end

    assign win_u    = r_iu[CW-1:0];
    assign win_v    = r_iv[CW-1:0];
    assign cell_u   = r_su + win_u;
    assign cell_v   = r_sv + win_v;
    assign cell_idx = r_cmd_q ? {cell_v, cell_u} : {r_v, r_u};
    assign ins_idx  = {r_v, r_u};

    shgrq_ram #(.WIDTH(shgrq_pkg::CNT_W), .DEPTH(shgrq_pkg::CELLS)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (ins_idx),
        .i_wdata (cnt_eff + 1'b1),
        .i_raddr (cell_idx),
        .o_rdata (cnt_rdata)
    );

    assign cnt_eff   = r_cvalid[cell_idx] ? cnt_rdata : '0;
    assign room      = cnt_eff < shgrq_pkg::CNT_W'(shgrq_pkg::BUCKET_DEPTH);
    assign cnt_we    = i_cmd.ins_commit && room;
    assign ent_we    = cnt_we;
    assign ent_waddr = shgrq_pkg::ADDR_W'(ins_idx) * shgrq_pkg::ADDR_W'(shgrq_pkg::BUCKET_DEPTH)
                     + shgrq_pkg::ADDR_W'(cnt_eff);
    assign ent_raddr = shgrq_pkg::ADDR_W'(cell_idx) * shgrq_pkg::ADDR_W'(shgrq_pkg::BUCKET_DEPTH)
                     + shgrq_pkg::ADDR_W'(r_c);
    assign ent_wdata = {r_id, r_px, r_py, r_pz};

    shgrq_ram #(.WIDTH(shgrq_pkg::ENTRY_W), .DEPTH(shgrq_pkg::SLOTS)) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (ent_wdata),
        .i_raddr (ent_raddr),
        .o_rdata (ent_rdata)
    );

    assign {e_id, e_x, e_y, e_z} = ent_rdata;

    always_comb begin
        case (i_cmd.sq)
            shgrq_pkg::SQ_X: begin sq_a = e_x; sq_b = r_px; end
            shgrq_pkg::SQ_Y: begin sq_a = e_y; sq_b = r_py; end
            default:         begin sq_a = e_z; sq_b = r_pz; end
        endcase
        diff = {sq_a[PW-1], sq_a} - {sq_b[PW-1], sq_b};
        mag  = diff[PW] ? PW'(-diff) : diff[PW-1:0];
    end

    assign d2     = r_acc + shgrq_pkg::D2_W'(r_sq);
    assign match  = d2 <= shgrq_pkg::D2_W'(r_r2);
    assign n_full = r_nmatch == shgrq_pkg::MCNT_W'(shgrq_pkg::MAX_MATCHES);

    always_comb begin
        emit      = 1'b0;
        emit_kind = shgrq_pkg::KIND_MATCH;
        emit_id   = '0;
        emit_last = 1'b0;
        emit_ovf  = 1'b0;
        if (i_cmd.ins_commit) begin
            emit      = 1'b1;
            emit_kind = room ? shgrq_pkg::KIND_INSERTED : shgrq_pkg::KIND_DROPPED;
            emit_last = 1'b1;
        end else if (i_cmd.match_take) begin
            emit    = match && !n_full && (r_nmatch != '0);
            emit_id = r_pend_id;
        end else if (i_cmd.emit_end) begin
            emit      = 1'b1;
            emit_last = 1'b1;
            if (r_nmatch == '0) begin
                emit_kind = shgrq_pkg::KIND_NONE;
            end else begin
                emit_id  = r_pend_id;
                emit_ovf = r_ovf;
            end
        end
    end

    assign out_free = !r_ovalid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bs     <= shgrq_pkg::BS_RESET;
            r_ovalid <= 1'b0;
            r_cvalid <= '{default: 1'b0};
        end else begin
            if (i_cfg_we) begin
                r_bs <= i_cfg_wdata;
            end
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            if (cnt_we) begin
                r_cvalid[ins_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cmd_q <= i_in.command;
            r_id    <= i_in.object_id;
            r_px    <= i_in.pos_x;
            r_py    <= i_in.pos_y;
            r_pz    <= i_in.pos_z;
            r_rad   <= i_in.radius;
            r_r2    <= i_in.radius * i_in.radius;
        end
        if (i_cmd.div_start) begin
            r_dsel <= i_cmd.div_sel;
        end
        if (div_done) begin
            case (r_dsel)
                shgrq_pkg::DIV_X: r_u <= cell_mod;
                shgrq_pkg::DIV_Y: r_v <= cell_mod;
                default: begin
                    r_full <= div_quo >= PW'(shgrq_pkg::GRID_SIDE / 2 - 1);
                    r_s    <= div_quo[CW-1:0] + 1'b1;
                end
            endcase
        end
        if (i_cmd.win_init) begin
            r_win_n  <= r_full ? shgrq_pkg::WIN_W'(shgrq_pkg::GRID_SIDE)
                               : {r_s, 1'b1};
            r_su     <= r_full ? '0 : r_u - r_s;
            r_sv     <= r_full ? '0 : r_v - r_s;
            r_iu     <= '0;
            r_iv     <= '0;
            r_nmatch <= '0;
            r_ovf    <= 1'b0;
        end
        if (i_cmd.cell_next) begin
            if (r_iu == r_win_n - 1'b1) begin
                r_iu <= '0;
                r_iv <= r_iv + 1'b1;
            end else begin
                r_iu <= r_iu + 1'b1;
            end
        end
        if (i_cmd.ent_first) begin
            r_c   <= '0;
            r_cnt <= cnt_eff;
        end else if (i_cmd.ent_next) begin
            r_c <= r_c + 1'b1;
        end
        if (i_cmd.sq != shgrq_pkg::SQ_NONE) begin
            r_sq <= mag * mag;
        end
        case (i_cmd.sq)
            shgrq_pkg::SQ_Y: r_acc <= shgrq_pkg::D2_W'(r_sq);
            shgrq_pkg::SQ_Z: r_acc <= r_acc + shgrq_pkg::D2_W'(r_sq);
            default:         r_acc <= r_acc;
        endcase
        if (i_cmd.match_take && match) begin
            if (!n_full) begin
                r_pend_id <= e_id;
                r_nmatch  <= r_nmatch + 1'b1;
            end else begin
                r_ovf <= 1'b1;
            end
        end
        if (emit) begin
            r_kind  <= emit_kind;
            r_oid   <= emit_id;
            r_olast <= emit_last;
            r_oovf  <= emit_ovf;
        end
    end

    assign o_out.valid    = r_ovalid;
    assign o_out.kind     = r_kind;
    assign o_out.found_id = r_oid;
    assign o_out.last     = r_olast;
    assign o_out.overflow = r_oovf;

    assign o_sts.div_done  = div_done;
    assign o_sts.is_query  = r_cmd_q == shgrq_pkg::CMD_QUERY;
    assign o_sts.cnt_zero  = cnt_eff == '0;
    assign o_sts.ent_last  = (r_c + 1'b1) == r_cnt;
    assign o_sts.cell_last = (r_iu == r_win_n - 1'b1) && (r_iv == r_win_n - 1'b1);
    assign o_sts.out_free  = out_free;
    assign o_sts.emit_need = match && !n_full && (r_nmatch != '0);
endmodule

### rtl/shgrq_ctrl.sv
// controller state machine sequencing insert and query steps
// depends on shgrq_pkg
module shgrq_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  shgrq_pkg::t_dp_sts    i_sts,
    output shgrq_pkg::t_ctrl_cmd  o_cmd
);
    shgrq_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= shgrq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.div_sel = shgrq_pkg::DIV_X;
        o_cmd.sq      = shgrq_pkg::SQ_NONE;
        case (r_state)
            shgrq_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = shgrq_pkg::ST_DX;
                end
            end
            shgrq_pkg::ST_DX: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = shgrq_pkg::DIV_X;
                n_state = shgrq_pkg::ST_DXW;
            end
            shgrq_pkg::ST_DXW: begin
                if (i_sts.div_done) n_state = shgrq_pkg::ST_DY;
            end
            shgrq_pkg::ST_DY: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = shgrq_pkg::DIV_Y;
                n_state = shgrq_pkg::ST_DYW;
            end
            shgrq_pkg::ST_DYW: begin
                if (i_sts.div_done) begin
                    n_state = i_sts.is_query ? shgrq_pkg::ST_DR : shgrq_pkg::ST_INS_RD;
                end
            end
            shgrq_pkg::ST_DR: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = shgrq_pkg::DIV_R;
                n_state = shgrq_pkg::ST_DRW;
            end
            shgrq_pkg::ST_DRW: begin
                if (i_sts.div_done) n_state = shgrq_pkg::ST_WIN;
            end
            shgrq_pkg::ST_WIN: begin
                o_cmd.win_init = 1'b1;
                n_state = shgrq_pkg::ST_CNT_RD;
            end
            shgrq_pkg::ST_INS_RD: begin
                n_state = shgrq_pkg::ST_INS_WR;
            end
            shgrq_pkg::ST_INS_WR: begin
                if (i_sts.out_free) begin
                    o_cmd.ins_commit = 1'b1;
                    n_state = shgrq_pkg::ST_IDLE;
                end
            end
            shgrq_pkg::ST_CNT_RD: begin
                n_state = shgrq_pkg::ST_CNT_CHK;
            end
            shgrq_pkg::ST_CNT_CHK: begin
                if (!i_sts.cnt_zero) begin
                    o_cmd.ent_first = 1'b1;
                    n_state = shgrq_pkg::ST_ENT_RD;
                end else if (i_sts.cell_last) begin
                    n_state = shgrq_pkg::ST_END;
                end else begin
                    o_cmd.cell_next = 1'b1;
                    n_state = shgrq_pkg::ST_CNT_RD;
                end
            end
            shgrq_pkg::ST_ENT_RD: begin
                n_state = shgrq_pkg::ST_SQ_X;
            end
            shgrq_pkg::ST_SQ_X: begin
                o_cmd.sq = shgrq_pkg::SQ_X;
                n_state = shgrq_pkg::ST_SQ_Y;
            end
            shgrq_pkg::ST_SQ_Y: begin
                o_cmd.sq = shgrq_pkg::SQ_Y;
                n_state = shgrq_pkg::ST_SQ_Z;
            end
            shgrq_pkg::ST_SQ_Z: begin
                o_cmd.sq = shgrq_pkg::SQ_Z;
                n_state = shgrq_pkg::ST_CMP;
            end
            shgrq_pkg::ST_CMP: begin
                if (!i_sts.emit_need || i_sts.out_free) begin
                    o_cmd.match_take = 1'b1;
                    if (!i_sts.ent_last) begin
                        o_cmd.ent_next = 1'b1;
                        n_state = shgrq_pkg::ST_ENT_RD;
                    end else if (i_sts.cell_last) begin
                        n_state = shgrq_pkg::ST_END;
                    end else begin
                        o_cmd.cell_next = 1'b1;
                        n_state = shgrq_pkg::ST_CNT_RD;
                    end
                end
            end
            shgrq_pkg::ST_END: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_end = 1'b1;
                    n_state = shgrq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = shgrq_pkg::ST_IDLE;
            end
        endcase
    end
endmodule

### rtl/spatial_hash_grid_radius_query_core.sv
// spatial hash grid radius query: one transaction at a time, input ready only while idle
// insert: two serial divides (x, y), count read and commit, then the result; a query adds a
// third divide (radius) and window setup, then a count read and check per scanned cell and an
// entry read, three squares and a compare per stored entry, then the last result; output
// stalls hold the flow, and the scan window reaches at most the whole 8x8 grid
// reset clears count valid bits and output valid, bucket size 1024; entries undefined until written
module spatial_hash_grid_radius_query_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    shgrq_in_if.sink                   i_in,
    shgrq_out_if.source                o_out,
    input  logic                       i_cfg_we,
    input  logic [shgrq_pkg::BS_W-1:0] i_cfg_wdata
);
    shgrq_pkg::t_ctrl_cmd cmd;
    shgrq_pkg::t_dp_sts   sts;

    shgrq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    shgrq_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );
endmodule

### tb/sv/tb_spatial_hash_grid_radius_query_core.sv
// testbench for spatial_hash_grid_radius_query_core: directed table, then random inserts and
// radius queries over several bucket sizes, all checked against an in-bench grid predictor
// depends on shgrq_pkg, shgrq_in_if, shgrq_out_if and the core
module tb_spatial_hash_grid_radius_query_core;
    import shgrq_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    typedef struct {
        logic             command;
        logic [ID_W-1:0]  object_id;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [POS_W-1:0] pos_z;
        logic [RAD_W-1:0] radius;
        bit               typed;
        t_kind            typed_kind;
    } t_cmd_row;

    typedef struct {
        t_kind           kind;
        logic [ID_W-1:0] found_id;
        logic            last;
        logic            overflow;
    } t_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [BS_W-1:0] i_cfg_wdata = '0;

    shgrq_in_if  in_ch ();
    shgrq_out_if out_ch ();

    spatial_hash_grid_radius_query_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // predictor state
    logic [BS_W-1:0] cell_edge;
    int              fill [CELLS];
    logic [ID_W-1:0] ent_id [CELLS][BUCKET_DEPTH];
    int              ent_x [CELLS][BUCKET_DEPTH];
    int              ent_y [CELLS][BUCKET_DEPTH];
    int              ent_z [CELLS][BUCKET_DEPTH];

    t_result pending_results[$];
    int      errors = 0;
    int      cycles = 0;
    int      n_insert = 0, n_query = 0, n_match = 0, n_ovf = 0, n_drop = 0;
    bit      quiet = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("[spatial_hash_grid_radius_query_core] ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        out_ch.ready <= quiet || ($urandom_range(99) >= 19);
    end

    task automatic report_mismatch(input string what, input int exp_v, input int got_v);
        errors++;
        $display("mismatch %s: expected %0d got %0d (cycle %0d)", what, exp_v, got_v, cycles);
    endtask

    function automatic int grid_cell(input int p, input int edge_len);
        int q, r;
        q = p / edge_len;
        if (p < 0 && (p % edge_len) != 0) q -= 1;
        r = q % GRID_SIDE;
        if (r < 0) r += GRID_SIDE;
        return r;
    endfunction

    function automatic longint unsigned sq_dist(input int a, input int b);
        longint d;
        d = longint'(a) - longint'(b);
        if (d < 0) d = -d;
        return longint'(d) * longint'(d);
    endfunction

    function automatic void add_result(input t_kind k, input logic [ID_W-1:0] id,
                                       input logic lst, input logic ovf);
        t_result r;
        r.kind = k;
        r.found_id = id;
        r.last = lst;
        r.overflow = ovf;
        pending_results.push_back(r);
    endfunction

    // computes the results of one accepted transaction and updates the grid copy
    function automatic t_kind grid_predict(input t_cmd_row c);
        int edge_len, px, py, pz, u, v, cidx, span, lo, hi, bu, bv, cu, cv, n;
        longint unsigned r2, d2, scan;
        bit ovf, full;
        edge_len = (cell_edge == 0) ? 1 : int'(cell_edge);
        px = int'($signed(c.pos_x));
        py = int'($signed(c.pos_y));
        pz = int'($signed(c.pos_z));
        u = grid_cell(px, edge_len);
        v = grid_cell(py, edge_len);
        if (c.command == CMD_INSERT) begin
            n_insert++;
            cidx = v * GRID_SIDE + u;
            if (fill[cidx] < BUCKET_DEPTH) begin
                ent_id[cidx][fill[cidx]] = c.object_id;
                ent_x[cidx][fill[cidx]] = px;
                ent_y[cidx][fill[cidx]] = py;
                ent_z[cidx][fill[cidx]] = pz;
                fill[cidx]++;
                add_result(KIND_INSERTED, '0, 1'b1, 1'b0);
                return KIND_INSERTED;
            end
            n_drop++;
            add_result(KIND_DROPPED, '0, 1'b1, 1'b0);
            return KIND_DROPPED;
        end
        n_query++;
        r2 = longint'(c.radius) * longint'(c.radius);
        scan = 1 + longint'(c.radius) / edge_len;
        full = (2 * scan) >= GRID_SIDE;
        span = full ? 0 : int'(scan);
        lo = full ? 0 : -span;
        hi = full ? GRID_SIDE - 1 : span;
        bu = full ? 0 : u;
        bv = full ? 0 : v;
        n = 0;
        ovf = 1'b0;
        for (int dv = lo; dv <= hi; dv++) begin
            cv = (bv + dv + GRID_SIDE) % GRID_SIDE;
            for (int du = lo; du <= hi; du++) begin
                cu = (bu + du + GRID_SIDE) % GRID_SIDE;
                cidx = cv * GRID_SIDE + cu;
                for (int e = 0; e < fill[cidx]; e++) begin
                    d2 = sq_dist(ent_x[cidx][e], px) + sq_dist(ent_y[cidx][e], py)
                       + sq_dist(ent_z[cidx][e], pz);
                    if (d2 <= r2) begin
                        if (n < MAX_MATCHES) begin
                            add_result(KIND_MATCH, ent_id[cidx][e], 1'b0, 1'b0);
                            n++;
                        end else begin
                            ovf = 1'b1;
                        end
                    end
                end
            end
        end
        if (n == 0) begin
            add_result(KIND_NONE, '0, 1'b1, 1'b0);
            return KIND_NONE;
        end
        n_match += n;
        if (ovf) n_ovf++;
        pending_results[$].last = 1'b1;
        pending_results[$].overflow = ovf;
        return KIND_MATCH;
    endfunction

    // result monitor, sampled mid-cycle so the next edge is the acceptance
    always @(negedge i_clk) begin
        t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                errors++;
                $display("unexpected result transaction kind %0d id %0d (cycle %0d)",
                         out_ch.kind, out_ch.found_id, cycles);
            end else begin
                want = pending_results.pop_front();
                if (out_ch.kind !== want.kind)
                    report_mismatch("kind", want.kind, out_ch.kind);
                if (out_ch.found_id !== want.found_id)
                    report_mismatch("found_id", want.found_id, out_ch.found_id);
                if (out_ch.last !== want.last)
                    report_mismatch("last", want.last, out_ch.last);
                if (out_ch.overflow !== want.overflow)
                    report_mismatch("overflow", want.overflow, out_ch.overflow);
            end
        end
    end

    task automatic send_cmd(input t_cmd_row c);
        t_kind k;
        if (!quiet && $urandom_range(99) < 19) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.command   <= c.command;
        in_ch.object_id <= c.object_id;
        in_ch.pos_x     <= c.pos_x;
        in_ch.pos_y     <= c.pos_y;
        in_ch.pos_z     <= c.pos_z;
        in_ch.radius    <= c.radius;
        do @(negedge i_clk); while (!in_ch.ready);
        @(posedge i_clk);
        k = grid_predict(c);
        if (c.typed && k != c.typed_kind)
            report_mismatch("predicted kind", c.typed_kind, k);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_edge(input logic [BS_W-1:0] val);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cell_edge = val;
    endtask

    function automatic logic [POS_W-1:0] rand_pos();
        if ($urandom_range(99) < 25) return POS_W'($urandom());
        return POS_W'(int'($urandom_range(0, 16383)) - 8192);
    endfunction

    function automatic t_cmd_row rand_cmd();
        t_cmd_row c;
        c.command   = ($urandom_range(99) < 55) ? CMD_INSERT : CMD_QUERY;
        c.object_id = ID_W'($urandom());
        c.pos_x     = rand_pos();
        c.pos_y     = rand_pos();
        c.pos_z     = rand_pos();
        case ($urandom_range(3))
            0: c.radius = RAD_W'($urandom());
            1: c.radius = RAD_W'($urandom_range(0, 64));
            default: c.radius = RAD_W'($urandom_range(0, 20000));
        endcase
        c.typed = 1'b0;
        c.typed_kind = KIND_MATCH;
        return c;
    endfunction

    function automatic t_cmd_row mk(input logic cmd, input int id, input int x, input int y,
                                    input int z, input int rad, input bit typed,
                                    input t_kind k);
        t_cmd_row c;
        c.command = cmd;
        c.object_id = ID_W'(id);
        c.pos_x = POS_W'(x);
        c.pos_y = POS_W'(y);
        c.pos_z = POS_W'(z);
        c.radius = RAD_W'(rad);
        c.typed = typed;
        c.typed_kind = k;
        return c;
    endfunction

    initial begin
        t_cmd_row table_rows[$];
        t_cmd_row c;
        in_ch.valid = 1'b0;
        in_ch.command = CMD_INSERT;
        in_ch.object_id = '0;
        in_ch.pos_x = '0;
        in_ch.pos_y = '0;
        in_ch.pos_z = '0;
        in_ch.radius = '0;
        out_ch.ready = 1'b0;
        cell_edge = BS_RESET;
        for (int i = 0; i < CELLS; i++) fill[i] = 0;

        table_rows.push_back(mk(CMD_QUERY,  0, 0, 0, 0, 0, 1, KIND_NONE));
        table_rows.push_back(mk(CMD_INSERT, 0, 0, 0, 0, 0, 1, KIND_INSERTED));
        table_rows.push_back(mk(CMD_QUERY,  0, 0, 0, 0, 0, 0, KIND_MATCH));
        table_rows.push_back(mk(CMD_INSERT, 65535, 8388607, 8388607, 8388607, 0, 1,
                                KIND_INSERTED));
        table_rows.push_back(mk(CMD_INSERT, 1, -8388608, -8388608, -8388608, 0, 1,
                                KIND_INSERTED));
        table_rows.push_back(mk(CMD_INSERT, 2, -1, -1, -1, 1048575, 1, KIND_INSERTED));
        table_rows.push_back(mk(CMD_INSERT, 3, -1024, -1025, 5, 0, 1, KIND_INSERTED));
        table_rows.push_back(mk(CMD_INSERT, 4, 5, 5, 5, 0, 1, KIND_INSERTED));
        table_rows.push_back(mk(CMD_INSERT, 5, 1023, 6, -7, 0, 1, KIND_INSERTED));
        table_rows.push_back(mk(CMD_INSERT, 6, 9, 1023, 9, 0, 1, KIND_DROPPED));
        table_rows.push_back(mk(CMD_INSERT, 7, 1, 1, 1, 0, 1, KIND_DROPPED));
        table_rows.push_back(mk(CMD_QUERY,  0, 0, 0, 0, 1048575, 0, KIND_MATCH));
        table_rows.push_back(mk(CMD_QUERY,  0, 8388607, 8388607, 8388607, 0, 0, KIND_MATCH));
        table_rows.push_back(mk(CMD_QUERY,  0, -8388608, -8388608, -8388608, 1, 0,
                                KIND_MATCH));
        table_rows.push_back(mk(CMD_QUERY,  0, 0, -1, 0, 1500, 0, KIND_MATCH));
        table_rows.push_back(mk(CMD_QUERY,  0, 0, 0, 0, 8, 0, KIND_MATCH));
        table_rows.push_back(mk(CMD_QUERY,  0, 3000, 3000, 0, 1023, 1, KIND_NONE));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (table_rows[i]) send_cmd(table_rows[i]);

        // zero bucket size acts as one
        write_edge('0);
        for (int i = 0; i < 6; i++) send_cmd(rand_cmd());
        write_edge(16'hFFFF);
        quiet = 1'b1;
        for (int i = 0; i < 6; i++) send_cmd(rand_cmd());
        quiet = 1'b0;
        write_edge(16'd1);
        for (int i = 0; i < 6; i++) send_cmd(rand_cmd());
        write_edge(16'($urandom_range(2, 4000)));
        for (int i = 0; i < 6; i++) send_cmd(rand_cmd());

        // pack a band of cells, then a full-grid query runs past the match cap
        write_edge(16'd16);
        for (int k = 0; k < 18; k++)
            for (int e = 0; e < BUCKET_DEPTH; e++) begin
                c = mk(CMD_INSERT, $urandom_range(0, 65535),
                       (k % GRID_SIDE) * 16 + $urandom_range(0, 15),
                       (k / GRID_SIDE) * 16 + $urandom_range(0, 15),
                       $urandom_range(0, 100), 0, 0, KIND_MATCH);
                send_cmd(c);
            end
        wait_drained();
        send_cmd(mk(CMD_QUERY, 0, 64, 64, 50, 1048575, 0, KIND_MATCH));
        send_cmd(mk(CMD_QUERY, 0, 64, 16, 50, 40, 0, KIND_MATCH));
        for (int i = 0; i < 5; i++) send_cmd(rand_cmd());

        wait_drained();
        repeat (500) @(posedge i_clk);
        $display("covered %0d inserts (%0d dropped) and %0d queries", n_insert, n_drop, n_query);
        $display("%0d matches checked, %0d capped queries", n_match, n_ovf);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("[spatial_hash_grid_radius_query_core] OK");
        end else begin
            $display("[spatial_hash_grid_radius_query_core] ERROR");
        end
        $finish;
    end
endmodule
